// ===== rtl/cab_pkg.sv =====
package cab_pkg;

  // Coordinate range; register saturation bound
  localparam int COORD_LIMIT = 4096;

  // Field widths
  localparam int PIX_W   = 12;
  localparam int DIM_W   = 13;
  localparam int POS_W   = 14;
  localparam int COLOR_W = 32;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  // Stream payload widths (whole bytes)
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FB_WIDTH    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FB_HEIGHT   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_X      = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_Y      = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_W      = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_H      = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_MODE = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_COLOR  = 4'd7;

  // Source select codes
  localparam logic SRC_FILL  = 1'b0;
  localparam logic SRC_TEXEL = 1'b1;

  // Reset values
  localparam logic [DIM_W-1:0]   FB_WIDTH_RST   = 13'd1280;
  localparam logic [DIM_W-1:0]   FB_HEIGHT_RST  = 13'd720;
  localparam logic [COLOR_W-1:0] FILL_COLOR_RST = 32'hFF00_0000;

  // Live configuration, rect_x/rect_y hold two's complement values
  typedef struct packed {
    logic [DIM_W-1:0]   fb_width;
    logic [DIM_W-1:0]   fb_height;
    logic [POS_W-1:0]   rect_x;
    logic [POS_W-1:0]   rect_y;
    logic [DIM_W-1:0]   rect_w;
    logic [DIM_W-1:0]   rect_h;
    logic               source_mode;
    logic [COLOR_W-1:0] fill_color;
  } cab_cfg_t;

  // One pixel item as held in the input register
  typedef struct packed {
    logic [COLOR_W-1:0] tex_color;
    logic [COLOR_W-1:0] dest_color;
    logic [PIX_W-1:0]   pixel_y;
    logic [PIX_W-1:0]   pixel_x;
  } cab_pix_t;

endpackage

// ===== rtl/cab_cfg.sv =====
module cab_cfg
  import cab_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cab_cfg_t              cfg_o
);

  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(COORD_LIMIT);
  localparam logic signed [POS_W-1:0] POS_MAX = POS_W'(COORD_LIMIT);
  localparam logic signed [POS_W-1:0] POS_MIN = POS_W'(-COORD_LIMIT);

  cab_cfg_t cfg_r;
  cab_cfg_t cfg_nxt;
  logic     wr_en;

  // Clamp a size to the coordinate limit
  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
    return (v > DIM_MAX) ? DIM_MAX : v;
  endfunction

  // Clamp a signed position to +/- coordinate limit
  function automatic logic [POS_W-1:0] sat_pos(input logic [POS_W-1:0] v);
    logic signed [POS_W-1:0] s;
    s = $signed(v);
    if (s > POS_MAX) begin
      s = POS_MAX;
    end else if (s < POS_MIN) begin
      s = POS_MIN;
    end
    return s;
  endfunction

  // Always ready; a write is registered and takes effect on the next cycle
  assign cfg_ready = 1'b1;
  assign wr_en     = cfg_valid && cfg_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_index)
        REG_FB_WIDTH:    cfg_nxt.fb_width    = sat_dim(cfg_data[DIM_W-1:0]);
        REG_FB_HEIGHT:   cfg_nxt.fb_height   = sat_dim(cfg_data[DIM_W-1:0]);
        REG_RECT_X:      cfg_nxt.rect_x      = sat_pos(cfg_data[POS_W-1:0]);
        REG_RECT_Y:      cfg_nxt.rect_y      = sat_pos(cfg_data[POS_W-1:0]);
        REG_RECT_W:      cfg_nxt.rect_w      = sat_dim(cfg_data[DIM_W-1:0]);
        REG_RECT_H:      cfg_nxt.rect_h      = sat_dim(cfg_data[DIM_W-1:0]);
        REG_SOURCE_MODE: cfg_nxt.source_mode = cfg_data[0];
        REG_FILL_COLOR:  cfg_nxt.fill_color  = cfg_data[COLOR_W-1:0];
        default: ;  // unknown index, dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fb_width    <= FB_WIDTH_RST;
      cfg_r.fb_height   <= FB_HEIGHT_RST;
      cfg_r.rect_x      <= '0;
      cfg_r.rect_y      <= '0;
      cfg_r.rect_w      <= '0;
      cfg_r.rect_h      <= '0;
      cfg_r.source_mode <= SRC_FILL;
      cfg_r.fill_color  <= FILL_COLOR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

// ===== rtl/cab_clip.sv =====
module cab_clip
  import cab_pkg::*;
(
  input  cab_cfg_t         cfg_i,
  input  logic [PIX_W-1:0] pixel_x,
  input  logic [PIX_W-1:0] pixel_y,
  output logic             hit
);

  // Wide enough for start + len and for the framebuffer edge
  localparam int SPAN_W = POS_W + 1;

  logic in_x;
  logic in_y;

  // start <= p < min(start + len, edge)
  function automatic logic in_span(input logic [PIX_W-1:0] p,
                                   input logic [POS_W-1:0] start,
                                   input logic [DIM_W-1:0] len,
                                   input logic [DIM_W-1:0] edge_px);
    logic signed [SPAN_W-1:0] p_s;
    logic signed [SPAN_W-1:0] start_s;
    logic signed [SPAN_W-1:0] end_s;
    logic signed [SPAN_W-1:0] edge_s;
    p_s     = $signed({{(SPAN_W-PIX_W){1'b0}}, p});
    start_s = $signed({start[POS_W-1], start});
    edge_s  = $signed({{(SPAN_W-DIM_W){1'b0}}, edge_px});
    end_s   = start_s + $signed({{(SPAN_W-DIM_W){1'b0}}, len});
    if (end_s > edge_s) begin
      end_s = edge_s;
    end
    return (p_s >= start_s) && (p_s < end_s);
  endfunction

  assign in_x = in_span(pixel_x, cfg_i.rect_x, cfg_i.rect_w, cfg_i.fb_width);
  assign in_y = in_span(pixel_y, cfg_i.rect_y, cfg_i.rect_h, cfg_i.fb_height);
  assign hit  = in_x && in_y;

endmodule

// ===== rtl/cab_blend.sv =====
module cab_blend
  import cab_pkg::*;
(
  input  cab_cfg_t           cfg_i,
  input  logic [COLOR_W-1:0] dest_color,
  input  logic [COLOR_W-1:0] tex_color,
  input  logic               hit,
  output logic [COLOR_W-1:0] out_color
);

  localparam int NUM_CH = 3;

  logic [COLOR_W-1:0] src;
  logic [7:0]         alpha;
  logic [7:0]         ch_res [NUM_CH];

  assign src   = (cfg_i.source_mode == SRC_TEXEL) ? tex_color : cfg_i.fill_color;
  assign alpha = src[31:24];

  // Per channel: (a*s + (255-a)*d + 127) / 255
  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    logic [7:0]  s_ch;
    logic [7:0]  d_ch;
    logic [15:0] p_src;
    logic [15:0] p_dst;
    logic [16:0] sum;
    logic [16:0] quo;

    assign s_ch  = src[8*c +: 8];
    assign d_ch  = dest_color[8*c +: 8];
    assign p_src = {8'd0, alpha} * {8'd0, s_ch};
    assign p_dst = (16'd255 - {8'd0, alpha}) * {8'd0, d_ch};
    assign sum   = {1'b0, p_src} + {1'b0, p_dst} + 17'd127;
    // Exact x/255 for x below 2^16: (x + (x >> 8) + 1) >> 8
    assign quo   = sum + (sum >> 8) + 17'd1;
    assign ch_res[c] = quo[15:8];
  end

  // Outside pixels pass the destination through untouched
  assign out_color = hit ? {alpha, ch_res[2], ch_res[1], ch_res[0]} : dest_color;

endmodule

// ===== rtl/clipped_alpha_blend_pixel.sv =====
// Clipped source-over alpha blend, one ARGB8888 pixel per transfer.
//
// Input stream: each transfer carries a framebuffer coordinate, the current
// destination pixel and, in bitmap mode, the matching texel. Output stream:
// one transfer per input, carrying the resulting pixel and an inside flag
// (out_tuser) that tells whether the pixel falls in the clipped rectangle.
// Pixels outside come back equal to the destination pixel.
//
// Config port: cfg_valid/cfg_ready with a register index and 32-bit data;
// always ready, a write takes effect on the next cycle. Write only while
// the block is drained.
//
// Timing: two register stages (input register, result register). An accepted
// pixel passes through the input register and then the result register,
// where out_tvalid rises; throughput is one pixel per cycle while the
// receiver keeps up, with combinational clip and blend logic between them.
// When the receiver stalls, the result register holds and the input
// register still takes one more pixel before in_tready drops.
// Reset (rst_n low, synchronous) empties both stages and loads the config
// defaults: 1280x720 framebuffer, empty rectangle, fill mode, opaque black.
module clipped_alpha_blend_pixel
  import cab_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Config write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Pixel input
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // pixel_x[11:0], pixel_y[23:12], dest_color[55:24], tex_color[87:56]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // Pixel result
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_color[31:0]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // inside_res[0]
  output logic                  out_tuser
);

  cab_cfg_t           cfg;
  cab_pix_t           pix_r;
  cab_pix_t           pix_nxt;
  logic               v1_r;
  logic               v1_nxt;
  logic               v2_r;
  logic               v2_nxt;
  logic [COLOR_W-1:0] color_r;
  logic [COLOR_W-1:0] color_nxt;
  logic               inside_r;
  logic               inside_nxt;
  logic               in_xfer;
  logic               adv;
  logic               inside_c;
  logic [COLOR_W-1:0] color_c;

  // Config registers
  cab_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  // Stage handshake: stage 1 frees when it moves to stage 2
  assign adv       = v1_r && (!v2_r || out_tready);
  assign in_tready = !v1_r || !v2_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    v1_nxt = v1_r;
    if (in_xfer) begin
      v1_nxt = 1'b1;
    end else if (adv) begin
      v1_nxt = 1'b0;
    end
    v2_nxt = v2_r;
    if (adv) begin
      v2_nxt = 1'b1;
    end else if (out_tready) begin
      v2_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  // Input register
  assign pix_nxt = in_xfer ? cab_pix_t'(in_tdata) : pix_r;

  always_ff @(posedge clk) begin
    pix_r <= pix_nxt;
  end

  // Clip test and blend
  cab_clip u_clip (
    .cfg_i   (cfg),
    .pixel_x (pix_r.pixel_x),
    .pixel_y (pix_r.pixel_y),
    .hit     (inside_c)
  );

  cab_blend u_blend (
    .cfg_i      (cfg),
    .dest_color (pix_r.dest_color),
    .tex_color  (pix_r.tex_color),
    .hit        (inside_c),
    .out_color  (color_c)
  );

  // Result register
  assign color_nxt  = adv ? color_c : color_r;
  assign inside_nxt = adv ? inside_c : inside_r;

  always_ff @(posedge clk) begin
    color_r  <= color_nxt;
    inside_r <= inside_nxt;
  end

  assign out_tvalid = v2_r;
  assign out_tdata  = color_r;
  assign out_tuser  = inside_r;

endmodule

// ===== rtl/cab_chk.sv =====
module cab_chk
  import cab_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser
);

  // Stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Reset empties the pipe
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A draining receiver never blocks the input
  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output drains");

  // Accepted pixel shows up as a valid result when the receiver keeps up
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) ##1 out_tready |=> out_tvalid)
    else $error("result missing after input transfer");

endmodule

bind clipped_alpha_blend_pixel cab_chk u_cab_chk (.*);
